@@ hdl/arf_pkg.sv @@
// shared types, constants and helpers for the advertising record type filter
package arf_pkg;

   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;

   localparam logic REG_TARGET = 1'b0;
   localparam logic REG_PREFIX = 1'b1;

   localparam logic [7:0]  TARGET_RESET = 8'hFF;
   localparam logic [23:0] PREFIX_RESET = 24'h02004C;

   localparam logic [1:0] PREFIX_BYTES = 2'd3;

   typedef struct packed {
      logic [7:0]  target_ad_type;
      logic [23:0] match_prefix;
   } cfg_type;

   function automatic logic [7:0] prefix_byte(input logic [23:0] prefix,
                                              input logic [1:0]  idx);
      logic [7:0] sel;
      case (idx)
         2'd0: sel = prefix[7:0];
         2'd1: sel = prefix[15:8];
         default: sel = prefix[23:16];
      endcase
      return sel;
   endfunction

endpackage

@@ hdl/arf_if.sv @@
// request and response channel interfaces
interface arf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       end_of_payload;

   modport source (output valid, output payload_byte, output end_of_payload, input ready);
   modport sink   (input valid, input payload_byte, input end_of_payload, output ready);
endinterface

interface arf_rsp_if;
   logic       valid;
   logic       ready;
   logic       type_found;
   logic [7:0] record_data_length;
   logic       prefix_match;

   modport source (output valid, output type_found, output record_data_length,
                   output prefix_match, input ready);
   modport sink   (input valid, input type_found, input record_data_length,
                   input prefix_match, output ready);
endinterface

@@ hdl/adv_record_type_prefix_filter.sv @@
// top level of the advertising record type and prefix filter
//
//   channel   direction   contents
//   req       in          payload_byte, end_of_payload
//   rsp       out         type_found, record_data_length, prefix_match
//   apb       in/out      target_ad_type at 0x0, match_prefix at 0x4
//
// one byte per cycle sustained, but for the stall below; each accepted byte is worked
// from the input register, and the final byte loads the result word onto rsp.
// reset puts the parser in the length phase and restores both registers to defaults.
// a result word held on rsp stalls req only when another final byte is waiting;
// other bytes keep flowing past the held word.
module adv_record_type_prefix_filter (
   input  logic                        clock,
   input  logic                        reset,
   arf_req_if.sink                     req,
   arf_rsp_if.source                   rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [arf_pkg::ADDR_W-1:0]  paddr,
   input  logic [arf_pkg::DATA_W-1:0]  pwdata,
   output logic [arf_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   arf_pkg::cfg_type cfg;

   arf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   arf_parse u_parse (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

@@ hdl/arf_csr.sv @@
// apb configuration registers
module arf_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [arf_pkg::ADDR_W-1:0]  paddr,
   input  logic [arf_pkg::DATA_W-1:0]  pwdata,
   output logic [arf_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output arf_pkg::cfg_type            cfg
);

   logic [7:0]  target_ff, target_in;
   logic [23:0] prefix_ff, prefix_in;
   logic        wr_en;
   logic        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[2];

   always_comb begin
      target_in = target_ff;
      prefix_in = prefix_ff;
      if (wr_en) begin
         case (reg_idx)
            arf_pkg::REG_TARGET: target_in = pwdata[7:0];
            arf_pkg::REG_PREFIX: prefix_in = pwdata[23:0];
            default: target_in = target_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= arf_pkg::TARGET_RESET;
         prefix_ff <= arf_pkg::PREFIX_RESET;
      end else begin
         target_ff <= target_in;
         prefix_ff <= prefix_in;
      end
   end

   always_comb begin
      case (reg_idx)
         arf_pkg::REG_TARGET: prdata = {24'd0, target_ff};
         arf_pkg::REG_PREFIX: prdata = {8'd0, prefix_ff};
         default: prdata = '0;
      endcase
   end

   assign cfg.target_ad_type = target_ff;
   assign cfg.match_prefix   = prefix_ff;

endmodule

@@ hdl/arf_parse.sv @@
// input register, record walk state and result register
module arf_parse (
   input  logic             clock,
   input  logic             reset,
   input  arf_pkg::cfg_type cfg,
   arf_req_if.sink          req,
   arf_rsp_if.source        rsp
);

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_TYPE = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   logic       in_valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       adv;

   phase_type  phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic [1:0] pidx_ff, pidx_in;
   logic       found_ff, found_in;
   logic       tgt_ff, tgt_in;
   logic       pok_ff, pok_in;
   logic [7:0] flen_ff, flen_in;

   logic [7:0] left_dec;
   logic       close_rec;
   logic       res_found;
   logic [7:0] res_len;
   logic       res_match;

   logic       rsp_valid_ff;
   logic       found_out_ff;
   logic [7:0] len_out_ff;
   logic       match_out_ff;

   assign adv       = in_valid_ff && (!last_ff || !rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         byte_ff <= req.payload_byte;
         last_ff <= req.end_of_payload;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      tgt_in    = tgt_ff;
      pok_in    = pok_ff;
      flen_in   = flen_ff;
      left_dec  = left_ff - 8'd1;
      close_rec = 1'b0;
      case (phase_ff)
         PH_TYPE: begin
            left_in = left_dec;
            if (!found_ff && byte_ff == cfg.target_ad_type) begin
               tgt_in  = 1'b1;
               flen_in = left_dec;
               pidx_in = 2'd0;
               pok_in  = 1'b1;
            end
            if (left_dec == 8'd0) begin
               close_rec = 1'b1;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (tgt_ff && pidx_ff != arf_pkg::PREFIX_BYTES) begin
               if (byte_ff != arf_pkg::prefix_byte(cfg.match_prefix, pidx_ff)) begin
                  pok_in = 1'b0;
               end
               pidx_in = pidx_ff + 2'd1;
            end
            left_in = left_dec;
            if (left_dec == 8'd0) begin
               close_rec = 1'b1;
            end
         end
         default: begin
            if (byte_ff != 8'd0) begin
               left_in  = byte_ff;
               phase_in = PH_TYPE;
            end else begin
               phase_in = PH_LEN;
            end
         end
      endcase
      if (close_rec) begin
         if (tgt_in) begin
            found_in = 1'b1;
            tgt_in   = 1'b0;
            if (pidx_in != arf_pkg::PREFIX_BYTES) begin
               pok_in = 1'b0;
            end
         end
         phase_in = PH_LEN;
      end
      res_found = found_in;
      res_len   = found_in ? flen_in : 8'd0;
      res_match = found_in && pok_in;
      if (last_ff) begin
         phase_in = PH_LEN;
         left_in  = 8'd0;
         pidx_in  = 2'd0;
         found_in = 1'b0;
         tgt_in   = 1'b0;
         pok_in   = 1'b1;
         flen_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         left_ff  <= 8'd0;
         pidx_ff  <= 2'd0;
         found_ff <= 1'b0;
         tgt_ff   <= 1'b0;
         pok_ff   <= 1'b1;
         flen_ff  <= 8'd0;
      end else if (adv) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         pidx_ff  <= pidx_in;
         found_ff <= found_in;
         tgt_ff   <= tgt_in;
         pok_ff   <= pok_in;
         flen_ff  <= flen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && last_ff) begin
         found_out_ff <= res_found;
         len_out_ff   <= res_len;
         match_out_ff <= res_match;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.type_found         = found_out_ff;
   assign rsp.record_data_length = len_out_ff;
   assign rsp.prefix_match       = match_out_ff;

   // a target record is only open until the first one closes
   a_tgt_not_found: assert property (@(posedge clock) disable iff (reset)
      tgt_ff |-> !found_ff)
      else $error("target record open after a record was found");

   a_last_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      adv && last_ff |=> rsp_valid_ff)
      else $error("final byte did not load a result word");

   a_match_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_out_ff |-> !match_out_ff && len_out_ff == 8'd0)
      else $error("result word reports data without a found record");

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_valid_ff && last_ff && rsp_valid_ff)
      else $error("input stalled without a pending result word");

endmodule
